@@ hw/rtl/cpu_interrupt_entry_sequencer_core_macros.svh @@
// Assertion macros for the interrupt entry sequencer checker.
// No dependencies; include by bare file name where assertions are written.
`ifndef CPU_INTERRUPT_ENTRY_SEQUENCER_CORE_MACROS_SVH
`define CPU_INTERRUPT_ENTRY_SEQUENCER_CORE_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define CIES_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cies assertion failed");

// Check a property at every rising edge, reset included.
`define CIES_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cies assertion failed");

`endif

@@ hw/rtl/cies_pkg.sv @@
// Types, codes and vector table for the interrupt entry sequencer.
// No dependencies; imported by every module of the block.
package cies_pkg;

   localparam int CIES_QUEUE_DEPTH = 2;

   localparam logic [15:0] CIES_PAGE_ONE  = 16'h0100;
   localparam logic [15:0] CIES_PAGE_MASK = 16'h00ff;
   localparam logic [7:0]  CIES_BREAK_BIT = 8'h10;
   localparam logic [7:0]  CIES_EMU_BIT   = 8'h20;
   localparam logic [7:0]  CIES_DEC_BIT   = 8'h08;
   localparam logic [7:0]  CIES_IRQ_BIT   = 8'h04;

   localparam logic [3:0] CIES_CYC_NATIVE = 4'd8;
   localparam logic [3:0] CIES_CYC_EMU    = 4'd7;
   localparam logic [3:0] CIES_CYC_IDLE   = 4'd1;
   localparam logic [3:0] CIES_CYC_NONE   = 4'd0;

   // Push slots: bank, PC high, PC low, status; the final item follows.
   localparam logic [2:0] CIES_SLOT_BANK   = 3'd0;
   localparam logic [2:0] CIES_SLOT_PC_HI  = 3'd1;
   localparam logic [2:0] CIES_SLOT_PC_LO  = 3'd2;
   localparam logic [2:0] CIES_SLOT_STATUS = 3'd3;
   localparam logic [2:0] CIES_SLOT_FINAL  = 3'd4;

   typedef enum logic [2:0] {
      FUNC_BOUNDARY = 3'd0,
      FUNC_NMI_REQ  = 3'd1,
      FUNC_SET_IRQ  = 3'd2,
      FUNC_STOP     = 3'd3,
      FUNC_WAIT     = 3'd4,
      FUNC_CLEAR    = 3'd5,
      FUNC_SOFT     = 3'd6
   } cies_func_type;

   typedef enum logic [2:0] {
      ACT_EXECUTE  = 3'd0,
      ACT_NMI      = 3'd1,
      ACT_IRQ      = 3'd2,
      ACT_SOFT     = 3'd3,
      ACT_STOPPED  = 3'd4,
      ACT_WAITING  = 3'd5,
      ACT_ACCEPTED = 3'd6
   } cies_action_type;

   typedef enum logic [2:0] {
      SRC_BRK   = 3'd0,
      SRC_COP   = 3'd1,
      SRC_ABORT = 3'd2,
      SRC_NMI   = 3'd3,
      SRC_IRQ   = 3'd4
   } cies_src_type;

   typedef struct packed {
      logic [2:0]  func;
      logic        irq_level;
      logic [1:0]  soft_kind;
      logic        emulation;
      logic [7:0]  status_in;
      logic [15:0] stack_in;
      logic [15:0] pc_in;
      logic [7:0]  bank_in;
   } cies_req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] push_address;
      logic [7:0]  push_data;
      logic [2:0]  action;
      logic [15:0] vector_address;
      logic [15:0] stack_out;
      logic [7:0]  status_out;
      logic [3:0]  cycles_used;
      logic        last;
   } cies_rsp_type;

   // Decision handed from the front to the back.
   typedef struct packed {
      cies_action_type action;
      logic            entry;
      logic            emu;
      cies_src_type    src;
      logic [3:0]      cycles;
      logic [7:0]      status;
      logic [15:0]     stack;
      logic [15:0]     pc;
      logic [7:0]      bank;
   } cies_job_type;

   function automatic logic [15:0] cies_vector(input logic emu, input cies_src_type src);
      logic [15:0] vec;
      unique case (src)
         SRC_BRK:   vec = emu ? 16'hfffe : 16'hffe6;
         SRC_COP:   vec = emu ? 16'hfff4 : 16'hffe4;
         SRC_ABORT: vec = emu ? 16'hfff8 : 16'hffe8;
         SRC_NMI:   vec = emu ? 16'hfffa : 16'hffea;
         SRC_IRQ:   vec = emu ? 16'hfffe : 16'hffee;
         default:   vec = 16'h0000;
      endcase
      return vec;
   endfunction

endpackage

@@ hw/rtl/cies_front.sv @@
// Front end: accepts events, keeps the interrupt and halt flags, classifies.
// Depends on cies_pkg; feeds decisions into cies_job_queue.
module cies_front import cies_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  cies_req_type req,
   output cies_job_type job
);

   logic irq_line_ff, irq_line_in;
   logic nmi_ff, nmi_in;
   logic halted_ff, halted_in;
   logic wait_ff, wait_in;
   logic [3:0] hw_cyc;

   assign hw_cyc = req.emulation ? CIES_CYC_EMU : CIES_CYC_NATIVE;

   always_comb begin
      irq_line_in = irq_line_ff;
      nmi_in      = nmi_ff;
      halted_in   = halted_ff;
      wait_in     = wait_ff;
      job.action  = ACT_ACCEPTED;
      job.entry   = 1'b0;
      job.emu     = req.emulation;
      job.src     = SRC_BRK;
      job.cycles  = CIES_CYC_NONE;
      job.status  = req.status_in;
      job.stack   = req.stack_in;
      job.pc      = req.pc_in;
      job.bank    = req.bank_in;
      unique case (req.func)
         FUNC_BOUNDARY: begin
            priority if (nmi_ff) begin
               nmi_in     = 1'b0;
               wait_in    = 1'b0;
               halted_in  = 1'b0;
               job.action = ACT_NMI;
               job.entry  = 1'b1;
               job.src    = SRC_NMI;
               job.cycles = hw_cyc;
            end else if (halted_ff) begin
               job.action = ACT_STOPPED;
               job.cycles = CIES_CYC_IDLE;
            end else if (irq_line_ff && ((req.status_in & CIES_IRQ_BIT) == 8'h00)) begin
               wait_in    = 1'b0;
               job.action = ACT_IRQ;
               job.entry  = 1'b1;
               job.src    = SRC_IRQ;
               job.cycles = hw_cyc;
            end else if (wait_ff && !irq_line_ff) begin
               job.action = ACT_WAITING;
               job.cycles = CIES_CYC_IDLE;
            end else begin
               // A waiting core woken by the line resumes execution.
               wait_in    = 1'b0;
               job.action = ACT_EXECUTE;
            end
         end
         FUNC_NMI_REQ: begin
            nmi_in  = 1'b1;
            wait_in = 1'b0;
         end
         FUNC_SET_IRQ: begin
            if (req.irq_level && !irq_line_ff) begin
               wait_in = 1'b0;
            end
            irq_line_in = req.irq_level;
         end
         FUNC_STOP: halted_in = 1'b1;
         FUNC_WAIT: wait_in = 1'b1;
         FUNC_CLEAR: begin
            irq_line_in = 1'b0;
            nmi_in      = 1'b0;
            halted_in   = 1'b0;
            wait_in     = 1'b0;
         end
         FUNC_SOFT: begin
            if (req.soft_kind != 2'd3) begin
               job.action = ACT_SOFT;
               job.entry  = 1'b1;
               job.src    = cies_src_type'({1'b0, req.soft_kind});
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_line_ff <= 1'b0;
         nmi_ff      <= 1'b0;
         halted_ff   <= 1'b0;
         wait_ff     <= 1'b0;
      end else if (accept) begin
         irq_line_ff <= irq_line_in;
         nmi_ff      <= nmi_in;
         halted_ff   <= halted_in;
         wait_ff     <= wait_in;
      end
   end

endmodule

@@ hw/rtl/cies_job_queue.sv @@
// Short queue of decisions between the front and back ends.
// Depends on cies_pkg for the decision type.
module cies_job_queue import cies_pkg::*; #(
   parameter int DEPTH = CIES_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cies_job_type push_job,
   output logic         full,
   output logic         head_valid,
   output cies_job_type head_job,
   input  logic         pop
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   cies_job_type          slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CntWidth'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/cies_back.sv @@
// Back end: expands a decision into stack writes and a final item.
// Depends on cies_pkg; reads the head of cies_job_queue.
module cies_back import cies_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cies_job_type head_job,
   output logic         head_pop,
   output logic         rsp_empty,
   output cies_rsp_type rsp_data,
   input  logic         rsp_pop
);

   logic         out_valid_ff, out_valid_in;
   cies_rsp_type out_ff, out_in;
   logic [2:0]   pos_ff, pos_in;
   logic [15:0]  sp_ff, sp_in;
   logic [15:0]  cur_sp;
   logic [15:0]  next_sp;
   logic [2:0]   slot;
   logic [7:0]   pushed_p;
   logic         can_load;
   logic         is_final;

   assign can_load = !out_valid_ff || rsp_pop;
   assign cur_sp   = (pos_ff == 3'd0) ? head_job.stack : sp_ff;
   // Emulation skips the bank push.
   assign slot     = pos_ff + {2'b00, head_job.emu};
   assign is_final = !head_job.entry || (slot == CIES_SLOT_FINAL);
   assign next_sp  = head_job.emu
                   ? (CIES_PAGE_ONE | ((cur_sp - 16'd1) & CIES_PAGE_MASK))
                   : (cur_sp - 16'd1);

   always_comb begin
      pushed_p = head_job.status;
      if (head_job.emu) begin
         pushed_p = (head_job.status | CIES_EMU_BIT) & ~CIES_BREAK_BIT;
         if (head_job.src == SRC_BRK) begin
            pushed_p = pushed_p | CIES_BREAK_BIT;
         end
      end
   end

   always_comb begin
      out_in       = '0;
      out_valid_in = out_valid_ff && !rsp_pop;
      pos_in       = pos_ff;
      sp_in        = sp_ff;
      head_pop     = 1'b0;
      if (can_load && head_valid) begin
         out_valid_in = 1'b1;
         if (is_final) begin
            head_pop           = 1'b1;
            pos_in             = 3'd0;
            out_in.kind        = 1'b1;
            out_in.last        = 1'b1;
            out_in.action      = head_job.action;
            out_in.cycles_used = head_job.cycles;
            if (head_job.entry) begin
               out_in.vector_address = cies_vector(head_job.emu, head_job.src);
               out_in.stack_out      = cur_sp;
               out_in.status_out     = (head_job.status & ~CIES_DEC_BIT) | CIES_IRQ_BIT;
            end else begin
               out_in.stack_out  = head_job.stack;
               out_in.status_out = head_job.status;
            end
         end else begin
            pos_in              = pos_ff + 3'd1;
            sp_in               = next_sp;
            out_in.push_address = head_job.emu
                                ? (CIES_PAGE_ONE | (cur_sp & CIES_PAGE_MASK)) : cur_sp;
            unique case (slot)
               CIES_SLOT_BANK:   out_in.push_data = head_job.bank;
               CIES_SLOT_PC_HI:  out_in.push_data = head_job.pc[15:8];
               CIES_SLOT_PC_LO:  out_in.push_data = head_job.pc[7:0];
               CIES_SLOT_STATUS: out_in.push_data = pushed_p;
               default:          out_in.push_data = 8'h00;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff <= sp_in;
      if (can_load && head_valid) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hw/rtl/cpu_interrupt_entry_sequencer_core.sv @@
// An event's result words pass the decision queue, then the back end's output register.
// Throughput: one event a cycle for events that answer with a single word, while the
// queue has room; an entry gives five result words in native mode and four in emulation,
// one word per cycle while the receiver pops. The decision queue decouples the two ends.
// Reset (synchronous, active high) clears the IRQ, NMI, stop and wait flags,
// empties the decision queue and the output register.
module cpu_interrupt_entry_sequencer_core import cies_pkg::*; #(
   parameter int QUEUE_DEPTH = CIES_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  cies_req_type req_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output cies_rsp_type rsp_data
);

   cies_job_type front_job;
   cies_job_type head_job;
   logic         accept;
   logic         head_valid;
   logic         head_pop;

   assign accept = req_push && !req_full;

   cies_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .job    (front_job)
   );

   cies_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_job   (front_job),
      .full       (req_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (head_pop)
   );

   cies_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data),
      .rsp_pop    (rsp_pop)
   );

endmodule

@@ hw/rtl/cies_checker.sv @@
// Port-level checks for the interrupt entry sequencer, bound to the top level.
// Depends on cies_pkg and cpu_interrupt_entry_sequencer_core_macros.svh.
`include "cpu_interrupt_entry_sequencer_core_macros.svh"

module cies_checker import cies_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_push,
   input logic         req_full,
   input cies_req_type req_data,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input cies_rsp_type rsp_data
);

   `CIES_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty)
   `CIES_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
   `CIES_ASSERT(a_write_fields, clock, reset,
      (!rsp_empty && !rsp_data.kind) |-> (!rsp_data.last && rsp_data.action == ACT_EXECUTE
      && rsp_data.cycles_used == 4'd0 && rsp_data.vector_address == 16'h0000))
   `CIES_ASSERT(a_final_fields, clock, reset,
      (!rsp_empty && rsp_data.kind) |-> (rsp_data.last && rsp_data.push_address == 16'h0000
      && rsp_data.push_data == 8'h00))
   // A boundary taken with the output idle brings a result word to the output.
   `CIES_ASSERT(a_boundary_answer, clock, reset,
      (req_push && !req_full && req_data.func == FUNC_BOUNDARY && rsp_empty) |=> ##1 !rsp_empty)

endmodule

bind cpu_interrupt_entry_sequencer_core cies_checker u_cies_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

@@ tb/sv/cpu_interrupt_entry_sequencer_core_tb.sv @@
// Self-checking testbench for cpu_interrupt_entry_sequencer_core: directed table, then random
// event sequences under three idle mixes. Depends on cies_pkg and the core RTL only.
`timescale 1ns / 100ps

module cpu_interrupt_entry_sequencer_core_tb;
   import cies_pkg::*;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam logic [1:0] SOFT_BRK    = 2'd0;
   localparam logic [1:0] SOFT_COP    = 2'd1;
   localparam logic [1:0] SOFT_ABORT  = 2'd2;
   localparam logic [1:0] SOFT_UNUSED = 2'd3;
   localparam int PLAN_ROWS   = 25;
   localparam int STALL_LIMIT = 3000;
   localparam int REQ_BITS    = $bits(cies_req_type);

   typedef struct {
      cies_req_type    req;
      logic            fixed;
      cies_action_type act;
      logic [3:0]      cyc;
   } plan_row_type;

   typedef struct {
      logic         fixed;
      cies_rsp_type word;
   } pinned_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   logic         req_full;
   cies_req_type req_data = '0;
   logic         rsp_empty;
   logic         rsp_pop = 1'b0;
   cies_rsp_type rsp_data;

   // Predictor state
   logic irq_line = 1'b0;
   logic nmi_pend = 1'b0;
   logic stopped  = 1'b0;
   logic waiting  = 1'b0;

   cies_rsp_type step_words [$];
   cies_rsp_type awaited_words [$];
   pinned_type   pinned_answers [$];
   plan_row_type plan [0:PLAN_ROWS-1];

   int fail_count   = 0;
   int stall_cycles = 0;
   int snd_idle     = 0;
   int rcv_idle     = 0;

   cpu_interrupt_entry_sequencer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic cies_rsp_type decision_word(cies_action_type act, logic [3:0] cyc,
                                                  cies_req_type r);
      cies_rsp_type w;
      w = '0;
      w.kind        = 1'b1;
      w.action      = act;
      w.stack_out   = r.stack_in;
      w.status_out  = r.status_in;
      w.cycles_used = cyc;
      w.last        = 1'b1;
      return w;
   endfunction

   function automatic logic [15:0] entry_vector(logic emu, cies_src_type src);
      case (src)
         SRC_BRK:   return emu ? 16'hfffe : 16'hffe6;
         SRC_COP:   return emu ? 16'hfff4 : 16'hffe4;
         SRC_ABORT: return emu ? 16'hfff8 : 16'hffe8;
         SRC_NMI:   return emu ? 16'hfffa : 16'hffea;
         default:   return emu ? 16'hfffe : 16'hffee;
      endcase
   endfunction

   function automatic void predict_entry(cies_req_type r, cies_src_type src,
                                         cies_action_type act, logic [3:0] cyc);
      logic [15:0]  sp;
      logic [7:0]   pushed_p;
      logic [7:0]   bytes [0:3];
      cies_rsp_type w;
      sp = r.stack_in;
      pushed_p = r.status_in;
      if (r.emulation) begin
         pushed_p = pushed_p | CIES_EMU_BIT;
         if (src == SRC_BRK) pushed_p = pushed_p | CIES_BREAK_BIT;
         else pushed_p = pushed_p & ~CIES_BREAK_BIT;
      end
      bytes[0] = r.bank_in;
      bytes[1] = r.pc_in[15:8];
      bytes[2] = r.pc_in[7:0];
      bytes[3] = pushed_p;
      // emulation mode skips the bank byte and keeps S in page one
      for (int i = r.emulation ? 1 : 0; i < 4; i++) begin
         w = '0;
         if (r.emulation) begin
            w.push_address = CIES_PAGE_ONE | (sp & CIES_PAGE_MASK);
            sp = CIES_PAGE_ONE | ((sp - 16'd1) & CIES_PAGE_MASK);
         end else begin
            w.push_address = sp;
            sp = sp - 16'd1;
         end
         w.push_data = bytes[i];
         step_words.push_back(w);
      end
      w = '0;
      w.kind           = 1'b1;
      w.action         = act;
      w.vector_address = entry_vector(r.emulation, src);
      w.stack_out      = sp;
      w.status_out     = (r.status_in & ~CIES_DEC_BIT) | CIES_IRQ_BIT;
      w.cycles_used    = cyc;
      w.last           = 1'b1;
      step_words.push_back(w);
   endfunction

   function automatic void predict_event(cies_req_type r);
      logic [3:0] hw_cyc;
      hw_cyc = r.emulation ? CIES_CYC_EMU : CIES_CYC_NATIVE;
      step_words.delete();
      case (r.func)
         FUNC_BOUNDARY: begin
            if (nmi_pend) begin
               nmi_pend = 1'b0;
               waiting  = 1'b0;
               stopped  = 1'b0;
               predict_entry(r, SRC_NMI, ACT_NMI, hw_cyc);
            end else if (stopped) begin
               step_words.push_back(decision_word(ACT_STOPPED, CIES_CYC_IDLE, r));
            end else if (irq_line && (r.status_in & CIES_IRQ_BIT) == 8'h00) begin
               waiting = 1'b0;
               predict_entry(r, SRC_IRQ, ACT_IRQ, hw_cyc);
            end else if (waiting && !irq_line) begin
               step_words.push_back(decision_word(ACT_WAITING, CIES_CYC_IDLE, r));
            end else begin
               // a masked IRQ still wakes the wait state
               waiting = 1'b0;
               step_words.push_back(decision_word(ACT_EXECUTE, CIES_CYC_NONE, r));
            end
         end
         FUNC_NMI_REQ: begin
            nmi_pend = 1'b1;
            waiting  = 1'b0;
         end
         FUNC_SET_IRQ: begin
            if (r.irq_level && !irq_line) waiting = 1'b0;
            irq_line = r.irq_level;
         end
         FUNC_STOP: stopped = 1'b1;
         FUNC_WAIT: waiting = 1'b1;
         FUNC_CLEAR: begin
            irq_line = 1'b0;
            nmi_pend = 1'b0;
            stopped  = 1'b0;
            waiting  = 1'b0;
         end
         FUNC_SOFT: begin
            if (r.soft_kind != SOFT_UNUSED)
               predict_entry(r, cies_src_type'({1'b0, r.soft_kind}), ACT_SOFT, CIES_CYC_NONE);
         end
         default: ;
      endcase
      if (step_words.size() == 0)
         step_words.push_back(decision_word(ACT_ACCEPTED, CIES_CYC_NONE, r));
   endfunction

   function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_word(cies_rsp_type got);
      cies_rsp_type want;
      if (awaited_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual %h", $time, got);
         fail_count++;
         return;
      end
      want = awaited_words.pop_front();
      check_field("kind", 16'(want.kind), 16'(got.kind));
      check_field("push_address", want.push_address, got.push_address);
      check_field("push_data", 16'(want.push_data), 16'(got.push_data));
      check_field("action", 16'(want.action), 16'(got.action));
      check_field("vector_address", want.vector_address, got.vector_address);
      check_field("stack_out", want.stack_out, got.stack_out);
      check_field("status_out", 16'(want.status_out), 16'(got.status_out));
      check_field("cycles_used", 16'(want.cycles_used), 16'(got.cycles_used));
      check_field("last", 16'(want.last), 16'(got.last));
   endfunction

   function automatic plan_row_type plan_row(logic [2:0] f, logic lvl, logic [1:0] sk, logic e,
                                             logic [7:0] p, logic [15:0] sp, logic [15:0] pc,
                                             logic [7:0] pb, logic fx, cies_action_type act,
                                             logic [3:0] cyc);
      plan_row_type row;
      row.req.func      = f;
      row.req.irq_level = lvl;
      row.req.soft_kind = sk;
      row.req.emulation = e;
      row.req.status_in = p;
      row.req.stack_in  = sp;
      row.req.pc_in     = pc;
      row.req.bank_in   = pb;
      row.fixed = fx;
      row.act   = act;
      row.cyc   = cyc;
      return row;
   endfunction

   function automatic cies_req_type random_word(logic [2:0] f);
      cies_req_type w;
      w = REQ_BITS'({$urandom, $urandom});
      w.func = f;
      if ($urandom_range(9) == 0) w.stack_in = $urandom_range(1) ? 16'hffff : 16'h0000;
      return w;
   endfunction

   // Receiver: pop at random, never during reset
   always @(posedge clock)
      rsp_pop <= !reset && ($urandom_range(99) >= rcv_idle);

   // Monitor: predict on each accepted event, check each accepted result word
   always @(posedge clock) begin
      pinned_type pin;
      if (!reset) begin
         if (req_push && !req_full) begin
            pin = pinned_answers.pop_front();
            predict_event(req_data);
            if (pin.fixed) awaited_words.push_back(pin.word);
            else foreach (step_words[i]) awaited_words.push_back(step_words[i]);
         end
         if (rsp_pop && !rsp_empty) check_word(rsp_data);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_word(cies_req_type w, logic fixed = 1'b0, cies_rsp_type fixed_word = '0);
      pinned_type pin;
      while ($urandom_range(99) < snd_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      pin.fixed = fixed;
      pin.word  = fixed_word;
      pinned_answers.push_back(pin);
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
   endtask

   task automatic run_random(int count);
      cies_req_type w;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(5))
            0: begin
               send_word(random_word(FUNC_NMI_REQ));
               send_word(random_word(FUNC_BOUNDARY));
            end
            1: begin
               w = random_word(FUNC_SET_IRQ);
               w.irq_level = 1'b1;
               send_word(w);
               w = random_word(FUNC_BOUNDARY);
               w.status_in = w.status_in & ~CIES_IRQ_BIT;
               send_word(w);
            end
            2: begin
               send_word(random_word(FUNC_WAIT));
               send_word(random_word(FUNC_BOUNDARY));
               send_word(random_word(FUNC_SET_IRQ));
               send_word(random_word(FUNC_BOUNDARY));
            end
            3: begin
               send_word(random_word(FUNC_STOP));
               send_word(random_word(FUNC_BOUNDARY));
               send_word(random_word($urandom_range(1) ? FUNC_NMI_REQ : FUNC_CLEAR));
               send_word(random_word(FUNC_BOUNDARY));
            end
            default: send_word(random_word(3'($urandom_range(7))));
         endcase
      end
   endtask

   initial begin
      plan[0]  = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h00, 16'h01ff, 16'h1234, 8'h12,
                          1, ACT_EXECUTE, CIES_CYC_NONE);
      plan[1]  = plan_row(FUNC_UNUSED, 1, SOFT_UNUSED, 1, 8'hff, 16'hffff, 16'hffff, 8'hff,
                          1, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[2]  = plan_row(FUNC_SOFT, 0, SOFT_UNUSED, 0, 8'h5a, 16'h8000, 16'h0001, 8'h80,
                          1, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[3]  = plan_row(FUNC_SOFT, 1, SOFT_BRK, 0, 8'hff, 16'h0000, 16'hffff, 8'hff,
                          0, ACT_SOFT, CIES_CYC_NONE);
      plan[4]  = plan_row(FUNC_SOFT, 0, SOFT_COP, 1, 8'h00, 16'h0100, 16'h0000, 8'h00,
                          0, ACT_SOFT, CIES_CYC_NONE);
      plan[5]  = plan_row(FUNC_SOFT, 0, SOFT_ABORT, 1, 8'hff, 16'h01ff, 16'habcd, 8'h7e,
                          0, ACT_SOFT, CIES_CYC_NONE);
      plan[6]  = plan_row(FUNC_SOFT, 0, SOFT_BRK, 1, 8'hef, 16'hff02, 16'h8000, 8'h01,
                          0, ACT_SOFT, CIES_CYC_NONE);
      plan[7]  = plan_row(FUNC_NMI_REQ, 0, SOFT_BRK, 0, 8'h24, 16'h01ff, 16'h0200, 8'h00,
                          1, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[8]  = plan_row(FUNC_SET_IRQ, 1, SOFT_BRK, 0, 8'h00, 16'h01ff, 16'h0200, 8'h00,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[9]  = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h00, 16'h1fff, 16'h4000, 8'h03,
                          0, ACT_NMI, CIES_CYC_NATIVE);
      plan[10] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 1, 8'h08, 16'h01fe, 16'hc123, 8'h00,
                          0, ACT_IRQ, CIES_CYC_EMU);
      plan[11] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h04, 16'h1ff0, 16'h4010, 8'h03,
                          0, ACT_EXECUTE, CIES_CYC_NONE);
      plan[12] = plan_row(FUNC_WAIT, 0, SOFT_BRK, 0, 8'h04, 16'h1ff0, 16'h4010, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[13] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h04, 16'h1ff0, 16'h4011, 8'h03,
                          0, ACT_EXECUTE, CIES_CYC_NONE);
      plan[14] = plan_row(FUNC_SET_IRQ, 0, SOFT_BRK, 0, 8'h04, 16'h1ff0, 16'h4012, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[15] = plan_row(FUNC_WAIT, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4012, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[16] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4013, 8'h03,
                          0, ACT_WAITING, CIES_CYC_IDLE);
      plan[17] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 1, 8'hff, 16'h01f0, 16'h4013, 8'h00,
                          0, ACT_WAITING, CIES_CYC_IDLE);
      plan[18] = plan_row(FUNC_SET_IRQ, 1, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4013, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[19] = plan_row(FUNC_STOP, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4014, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[20] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4015, 8'h03,
                          0, ACT_STOPPED, CIES_CYC_IDLE);
      plan[21] = plan_row(FUNC_NMI_REQ, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4015, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[22] = plan_row(FUNC_BOUNDARY, 1, SOFT_BRK, 1, 8'hfb, 16'hffff, 16'h00ff, 8'hff,
                          0, ACT_NMI, CIES_CYC_EMU);
      plan[23] = plan_row(FUNC_CLEAR, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4016, 8'h03,
                          0, ACT_ACCEPTED, CIES_CYC_NONE);
      plan[24] = plan_row(FUNC_BOUNDARY, 0, SOFT_BRK, 0, 8'h00, 16'h1ff0, 16'h4017, 8'h03,
                          0, ACT_EXECUTE, CIES_CYC_NONE);

      snd_idle = 29;
      rcv_idle = 78;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < PLAN_ROWS; n++)
         send_word(plan[n].req, plan[n].fixed,
                   decision_word(plan[n].act, plan[n].cyc, plan[n].req));
      run_random(21);

      snd_idle = 78;
      rcv_idle = 29;
      run_random(21);

      snd_idle = 0;
      rcv_idle = 0;
      run_random(21);

      // drop push, let the monitor see the last event, then drain
      req_push <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cies_pkg.sv
hw/rtl/cies_front.sv
hw/rtl/cies_job_queue.sv
hw/rtl/cies_back.sv
hw/rtl/cpu_interrupt_entry_sequencer_core.sv
hw/rtl/cies_checker.sv
tb/sv/cpu_interrupt_entry_sequencer_core_tb.sv
